FILE: rtl/sidta_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
`default_nettype none

package sidta_pkg;

    // Field widths and conversion sizes
    localparam int MagWidth   = 32;
    localparam int CharWidth  = 7;
    localparam int NumDigits  = 10;
    localparam int CntWidth   = $clog2(MagWidth);
    localparam int PtrWidth   = $clog2(NumDigits);

    // ASCII codes
    localparam logic [CharWidth-1:0] CharZero  = 7'h30;
    localparam logic [CharWidth-1:0] CharMinus = 7'h2D;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the input value and clear the BCD register
        logic shift;  // one double-dabble step
        logic find;   // locate the leading nonzero digit
        logic emit;   // load the next character into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_bit;   // the current shift consumes the final magnitude bit
        logic out_free;   // output register can take a character this cycle
        logic emit_last;  // the next emitted character ends the number
    } t_status;

endpackage : sidta_pkg

`default_nettype wire

FILE: rtl/signed_int_to_decimal_ascii_top.sv
// Usage of the signed integer to decimal ASCII converter:
// The slave channel takes one transaction per number: s_tdata holds the
// 32-bit two's complement value. The master channel gives one transaction
// per character: m_tdata holds the 7-bit ASCII code ('-' or '0'..'9'),
// m_tlast marks the final character of the number.
// Once a value is accepted the magnitude runs through a double-dabble
// converter, one bit per cycle, then a search state locates the leading
// digit. Characters then leave one per cycle unless m_tready stalls them.
// s_tready is high only while no number is in conversion or emission; the
// final character may still sit in the output register while the next value
// is accepted and converted.
// A stall on m_tready holds the current character and pauses emission; no
// character is lost or repeated.
// Reset (i_rst_n low, synchronous) returns the controller to idle and empties
// the output register.
`default_nettype none

module signed_int_to_decimal_ascii_top
    import sidta_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] character, [7] zero
    output logic             m_tlast    // last
);

    t_cmd                 w_cmd;
    t_status              w_status;
    logic [CharWidth-1:0] w_char;

    sidta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sidta_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (s_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_out_char  (w_char),
        .o_out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, w_char};

endmodule : signed_int_to_decimal_ascii_top

`default_nettype wire

FILE: rtl/sidta_ctrl.sv
// Controller state machine: sequences load, conversion, digit search and emission.
`default_nettype none

module sidta_ctrl
    import sidta_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_FIND = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode commands and next state
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                if (i_status.last_bit) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule : sidta_ctrl

`default_nettype wire

FILE: rtl/sidta_dp.sv
// Datapath: magnitude shift register, BCD digits, digit pointer and output register.
`default_nettype none

module sidta_dp
    import sidta_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [MagWidth-1:0]  i_value,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [CharWidth-1:0]      o_out_char,
    output logic                      o_out_last
);

    localparam logic [CntWidth-1:0] CntLast = CntWidth'(MagWidth - 1);

    logic [MagWidth-1:0]      r_mag;
    logic [4*NumDigits-1:0]   r_bcd;
    logic [4*NumDigits-1:0]   n_bcd_adj;
    logic                     r_neg;
    logic [CntWidth-1:0]      r_cnt;
    logic [PtrWidth-1:0]      r_ptr;
    logic [PtrWidth-1:0]      n_top;
    logic                     r_sign_pend;
    logic [3:0]               n_digit;
    logic                     r_ovalid;
    logic [CharWidth-1:0]     r_ochar;
    logic                     r_olast;
    logic                     n_out_free;

    // Add three to every digit of five or more before the shift
    always_comb begin
        logic [3:0] d;
        for (int k = 0; k < NumDigits; k++) begin
            d = r_bcd[4*k +: 4];
            n_bcd_adj[4*k +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    // Locate the most significant nonzero digit; zero keeps the lowest digit
    always_comb begin
        n_top = '0;
        for (int k = 0; k < NumDigits; k++) begin
            if (r_bcd[4*k +: 4] != 4'd0) begin
                n_top = PtrWidth'(k);
            end
        end
    end

    assign n_digit    = r_bcd[4*r_ptr +: 4];
    assign n_out_free = !r_ovalid || i_out_ready;

    assign o_status.last_bit  = (r_cnt == CntLast);
    assign o_status.out_free  = n_out_free;
    assign o_status.emit_last = !r_sign_pend && (r_ptr == '0);

    // Conversion registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[MagWidth-1];
            r_mag <= i_value[MagWidth-1] ? (~i_value + 1'b1) : i_value;
            r_bcd <= '0;
            r_cnt <= '0;
        end else if (i_cmd.shift) begin
            r_bcd <= {n_bcd_adj[4*NumDigits-2:0], r_mag[MagWidth-1]};
            r_mag <= {r_mag[MagWidth-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.find) begin
            r_ptr       <= n_top;
            r_sign_pend <= r_neg;
        end else if (i_cmd.emit) begin
            if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else begin
                r_ptr <= r_ptr - 1'b1;
            end
        end
    end

    // Output register: load a character or drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_sign_pend) begin
                r_ochar <= CharMinus;
                r_olast <= 1'b0;
            end else begin
                r_ochar <= CharZero + CharWidth'(n_digit);
                r_olast <= (r_ptr == '0);
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_char  = r_ochar;
    assign o_out_last  = r_olast;

endmodule : sidta_dp

`default_nettype wire

FILE: rtl/sidta_chk.sv
// Port-level checker for the converter, bound to the top level.
`default_nettype none

module sidta_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast
);

    // Stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    // Only digits and the minus sign leave the block
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata == 8'h2D) || ((m_tdata >= 8'h30) && (m_tdata <= 8'h39)))
        else $error("character outside digit and minus set");

    // A minus sign never ends a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata == 8'h2D) |-> !m_tlast)
        else $error("minus sign marked last");

    // An accepted value blocks the input right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted transaction");

    // Input reopens only after a last character was handed to the output
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(s_tready) |-> m_tvalid && m_tlast)
        else $error("input reopened before the last character");

endmodule : sidta_chk

bind signed_int_to_decimal_ascii_top sidta_chk u_sidta_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
